[src/pkh_pkg.sv]
// ----------------------------------------------------------------------------
// pkh_pkg
// Shared types, constants and the softplus table for the pair-key hash map.
// ----------------------------------------------------------------------------
package pkh_pkg;

	localparam int TABLE_SLOTS = 1024;
	localparam int SLOT_W      = $clog2(TABLE_SLOTS);
	localparam int CNT_W       = SLOT_W + 1;
	localparam int SLOT_MEM_W  = SLOT_W + 1;
	localparam int KEY_W       = 64;
	localparam int VAL_W       = 32;
	localparam int ENT_MEM_W   = KEY_W + VAL_W;
	localparam int IDX_W       = 10;
	localparam int MAXFILL_W   = 11;
	localparam logic [MAXFILL_W-1:0] MAXFILL_RST = 11'd512;

	localparam int SP_ENTRIES = 256;
	localparam int SP_W       = $clog2(SP_ENTRIES);
	localparam int SP_SHIFT   = 12;
	localparam int SP_VAL_W   = 16;

	localparam logic [VAL_W-1:0] VAL_MISS = 32'hFFFF_0000;
	localparam logic [VAL_W-1:0] VAL_MAX  = 32'h7FFF_FFFF;

	localparam logic [63:0] PR1   = 64'h9E37_79B1_85EB_CA87;
	localparam logic [63:0] PR2   = 64'hC2B2_AE3D_27D4_EB4F;
	localparam logic [63:0] PR3   = 64'h1656_67B1_9E37_79F9;
	localparam logic [63:0] PR4   = 64'h85EB_CA77_C2B2_AE63;
	localparam logic [63:0] PR5   = 64'h27D4_EB2F_1656_67C5;
	localparam logic [63:0] HSEED = 64'd1337;
	localparam logic [63:0] H_INIT = HSEED + PR5 + 64'd8;

	localparam logic [63:0] EXP_STEP_Q30 = 64'd1008687096;
	localparam logic [63:0] ONE_Q30      = 64'd1 << 30;

	typedef enum logic [1:0] {
		ACT_LOOKUP = 2'd0,
		ACT_INSERT = 2'd1,
		ACT_ACCUM  = 2'd2,
		ACT_CLEAR  = 2'd3
	} action_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_SLOT_RD,
		ST_SLOT_CHK,
		ST_KEY_CMP,
		ST_LOGADD,
		ST_RESP
	} st_t;

	typedef struct packed {
		logic              done;
		logic [SLOT_W-1:0] slot;
	} hash_res_t;

	typedef logic [SP_VAL_W-1:0] sp_tab_t [SP_ENTRIES];

	// restoring division, used only while building the table
	function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
		logic [64:0] rem;
		logic [63:0] q;
		rem = '0;
		q   = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[63:0], n[i]};
			if (rem >= {1'b0, d}) begin
				rem  = rem - {1'b0, d};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic [SP_VAL_W-1:0] ln1p_q16(input logic [63:0] t);
		logic [63:0] z;
		logic [63:0] z2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] k;
		logic [63:0] rnd;
		z    = udiv64(t << 30, (64'd2 << 30) + t);
		z2   = (z * z) >> 30;
		term = z;
		sum  = '0;
		k    = 64'd1;
		for (int j = 0; j < 64; j++) begin
			if (term != 64'd0) begin
				sum  = sum + udiv64(term, k);
				term = (term * z2) >> 30;
				k    = k + 64'd2;
			end
		end
		rnd = (64'd2 * sum + (64'd1 << 13)) >> 14;
		return rnd[SP_VAL_W-1:0];
	endfunction

	function automatic sp_tab_t sp_build();
		sp_tab_t     tab;
		logic [63:0] e;
		e = ONE_Q30;
		for (int i = 0; i < SP_ENTRIES; i++) begin
			tab[i] = ln1p_q16(e);
			e      = (e * EXP_STEP_Q30 + (64'd1 << 29)) >> 30;
		end
		return tab;
	endfunction

	localparam sp_tab_t SP_TABLE = sp_build();

endpackage

[src/pkh_if.sv]
// ----------------------------------------------------------------------------
// pkh_req_if / pkh_rsp_if
// Valid/ready channels for map requests and their responses.
// ----------------------------------------------------------------------------
interface pkh_req_if;
	logic              valid;
	logic              ready;
	logic [1:0]        action;
	logic signed [31:0] key_x;
	logic signed [31:0] key_y;
	logic signed [31:0] value_in;

	modport source (output valid, action, key_x, key_y, value_in, input ready);
	modport sink   (input valid, action, key_x, key_y, value_in, output ready);
endinterface

interface pkh_rsp_if;
	logic               valid;
	logic               ready;
	logic               found;
	logic signed [31:0] value_out;
	logic [9:0]         entry_index;
	logic               status;

	modport source (output valid, found, value_out, entry_index, status, input ready);
	modport sink   (input valid, found, value_out, entry_index, status, output ready);
endinterface

[src/pkh_ram.sv]
// ----------------------------------------------------------------------------
// pkh_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module pkh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

[src/pkh_hash.sv]
// ----------------------------------------------------------------------------
// pkh_hash
// Home slot from an 8-byte XXH64 over the key pair, one 32x32 multiplier
// shared over five 64-bit products of three partial products each.
// ----------------------------------------------------------------------------
module pkh_hash import pkh_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [KEY_W-1:0]  lane,
	output hash_res_t         res
);

	localparam logic [2:0] OP_LAST = 3'd4;
	localparam logic [1:0] PH_LAST = 2'd3;

	logic [63:0] x_q;
	logic [63:0] acc_q;
	logic [63:0] prod_q;
	logic [2:0]  op_q;
	logic [1:0]  ph_q;
	logic        busy_q;
	logic        done_q;
	logic [SLOT_W-1:0] slot_q;

	logic [63:0] b;
	logic [31:0] ma;
	logic [31:0] mb;
	logic [63:0] pp;
	logic [63:0] acc_sum;
	logic [63:0] t;
	logic [63:0] nx;

	always_comb begin
		case (op_q)
			3'd0:    b = PR2;
			3'd1:    b = PR1;
			3'd2:    b = PR1;
			3'd3:    b = PR2;
			default: b = PR3;
		endcase
		case (ph_q)
			2'd0:    begin ma = x_q[31:0];  mb = b[31:0];  end
			2'd1:    begin ma = x_q[63:32]; mb = b[31:0];  end
			default: begin ma = x_q[31:0];  mb = b[63:32]; end
		endcase
	end

	assign pp      = 64'(ma) * 64'(mb);
	assign acc_sum = acc_q + {prod_q[31:0], 32'b0};
	assign t       = acc_sum + PR4;

	// mixing step that follows each product but the last
	always_comb begin
		case (op_q)
			3'd0:    nx = {acc_sum[32:0], acc_sum[63:33]};
			3'd1:    nx = {(H_INIT[36:0] ^ acc_sum[36:0]), (H_INIT[63:37] ^ acc_sum[63:37])};
			3'd2:    nx = t ^ {33'b0, t[63:33]};
			3'd3:    nx = acc_sum ^ {29'b0, acc_sum[63:29]};
			default: nx = acc_sum;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= '0;
			ph_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				op_q   <= '0;
				ph_q   <= '0;
			end else if (busy_q) begin
				ph_q <= ph_q + 2'd1;
				if (ph_q == PH_LAST) begin
					op_q <= op_q + 3'd1;
					if (op_q == OP_LAST) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= lane;
		end else if (busy_q) begin
			if (ph_q != PH_LAST) begin
				prod_q <= pp;
			end
			case (ph_q)
				2'd1:    acc_q <= prod_q;
				2'd2:    acc_q <= acc_sum;
				default: ;
			endcase
			if (ph_q == PH_LAST) begin
				x_q <= nx;
				if (op_q == OP_LAST) begin
					slot_q <= acc_sum[SLOT_W-1:0] ^ acc_sum[32+SLOT_W-1:32];
				end
			end
		end
	end

	assign res.done = done_q;
	assign res.slot = slot_q;

endmodule

[src/pair_key_hash_map_log_accumulate.sv]
// ----------------------------------------------------------------------------
// pair_key_hash_map_log_accumulate
// Linear-probing hash map on a signed key pair, with Q16.16 log-add update.
// ----------------------------------------------------------------------------
//  channel | dir | handshake        | payload
//  req     | in  | valid/ready      | action, key_x, key_y, value_in
//  rsp     | out | valid/ready      | found, value_out, entry_index, status
//  cfg     | in  | cfg_we, no wait  | cfg_wdata = max_fill
//
// One request at a time. A request is accepted and hashed (five 64-bit
// products over one shared 32x32 multiplier); each slot probed is read and
// checked, each stored key met by a lookup or accumulate is compared, an
// accumulate hit does a log-add, and the response is handed over. Clear
// sweeps the slot RAM, and after reset it runs before the first request.
// A stalled response holds in the output register; the next request is taken
// meanwhile and waits only at its own hand-over.
// ----------------------------------------------------------------------------
module pair_key_hash_map_log_accumulate import pkh_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [MAXFILL_W-1:0] cfg_wdata,
	pkh_req_if.sink              req,
	pkh_rsp_if.source            rsp
);

	st_t st_q, st_d;

	action_t           act_q;
	logic [KEY_W-1:0]  lane_q;
	logic [VAL_W-1:0]  val_q;
	logic [SLOT_W-1:0] slot_q;
	logic [SLOT_W-1:0] n_q;
	logic [SLOT_W-1:0] ent_q;
	logic [CNT_W-1:0]  count_q;
	logic [MAXFILL_W-1:0] max_fill_q;
	logic [SLOT_W-1:0] clr_q;
	logic              clr_resp_q;

	logic [VAL_W-1:0]  big_q;
	logic [SP_W-1:0]   spi_q;
	logic              spok_q;

	logic              res_found_q;
	logic [VAL_W-1:0]  res_val_q;
	logic [IDX_W-1:0]  res_idx_q;
	logic              res_status_q;

	logic              ov_q;
	logic              o_found_q;
	logic [VAL_W-1:0]  o_val_q;
	logic [IDX_W-1:0]  o_idx_q;
	logic              o_status_q;

	logic                  slot_we;
	logic [SLOT_W-1:0]     slot_addr;
	logic [SLOT_MEM_W-1:0] slot_wd;
	logic [SLOT_MEM_W-1:0] slot_rd;
	logic                  ent_we;
	logic [SLOT_W-1:0]     ent_addr;
	logic [ENT_MEM_W-1:0]  ent_wd;
	logic [ENT_MEM_W-1:0]  ent_rd;

	hash_res_t hres;
	logic      accept;
	logic      hash_start;

	logic              sv;
	logic [SLOT_W-1:0] se;
	logic              key_hit;
	logic              full_c;
	logic              do_insert;
	logic              advance;
	logic              exhausted;
	logic              out_free;

	logic signed [VAL_W-1:0] va;
	logic signed [VAL_W-1:0] vb;
	logic signed [VAL_W-1:0] vbig;
	logic signed [VAL_W-1:0] vsmall;
	logic [VAL_W:0]          diff;
	logic [SP_VAL_W-1:0]     sp;
	logic [VAL_W:0]          sum33;
	logic [VAL_W-1:0]        r_add;

	assign accept     = req.valid && req.ready;
	assign hash_start = accept && (action_t'(req.action) != ACT_CLEAR);
	assign out_free   = !ov_q || rsp.ready;

	assign sv      = slot_rd[SLOT_MEM_W-1];
	assign se      = slot_rd[SLOT_W-1:0];
	assign key_hit = ent_rd[ENT_MEM_W-1:VAL_W] == lane_q;
	assign full_c  = (32'(count_q) >= 32'(max_fill_q)) || (32'(count_q) >= 32'(TABLE_SLOTS));

	assign do_insert = (st_q == ST_SLOT_CHK) && !sv && (act_q != ACT_LOOKUP) && !full_c;
	assign advance   = ((st_q == ST_SLOT_CHK) && sv && (act_q == ACT_INSERT))
	                || ((st_q == ST_KEY_CMP) && !key_hit);
	assign exhausted = advance && (n_q == '1);

	// log-add: ordering and difference in the compare cycle, table and sum after
	assign va     = ent_rd[VAL_W-1:0];
	assign vb     = val_q;
	assign vbig   = (va > vb) ? va : vb;
	assign vsmall = (va > vb) ? vb : va;
	assign diff   = {vbig[VAL_W-1], vbig} - {vsmall[VAL_W-1], vsmall};
	assign sp     = spok_q ? SP_TABLE[spi_q] : '0;
	assign sum33  = {big_q[VAL_W-1], big_q} + (VAL_W+1)'(sp);
	assign r_add  = (!big_q[VAL_W-1] && sum33[VAL_W-1]) ? VAL_MAX : sum33[VAL_W-1:0];

	pkh_hash u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hash_start),
		.lane   ({req.key_y, req.key_x}),
		.res    (hres)
	);

	pkh_ram #(.WIDTH(SLOT_MEM_W), .DEPTH(TABLE_SLOTS)) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.addr  (slot_addr),
		.wdata (slot_wd),
		.rdata (slot_rd)
	);

	pkh_ram #(.WIDTH(ENT_MEM_W), .DEPTH(TABLE_SLOTS)) u_ent_ram (
		.clk   (clk),
		.we    (ent_we),
		.addr  (ent_addr),
		.wdata (ent_wd),
		.rdata (ent_rd)
	);

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_CLEAR: begin
				if (clr_q == '1) begin
					st_d = clr_resp_q ? ST_RESP : ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					st_d = (action_t'(req.action) == ACT_CLEAR) ? ST_CLEAR : ST_HASH;
				end
			end
			ST_HASH: begin
				if (hres.done) begin
					st_d = ST_SLOT_RD;
				end
			end
			ST_SLOT_RD:  st_d = ST_SLOT_CHK;
			ST_SLOT_CHK: begin
				if (!sv) begin
					st_d = ST_RESP;
				end else if (act_q == ACT_INSERT) begin
					st_d = exhausted ? ST_RESP : ST_SLOT_RD;
				end else begin
					st_d = ST_KEY_CMP;
				end
			end
			ST_KEY_CMP: begin
				if (key_hit) begin
					st_d = (act_q == ACT_ACCUM) ? ST_LOGADD : ST_RESP;
				end else begin
					st_d = exhausted ? ST_RESP : ST_SLOT_RD;
				end
			end
			ST_LOGADD: st_d = ST_RESP;
			ST_RESP: begin
				if (out_free) begin
					st_d = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	// memory controls and handshake
	always_comb begin
		slot_we   = 1'b0;
		slot_addr = slot_q;
		slot_wd   = '0;
		ent_we    = 1'b0;
		ent_addr  = ent_q;
		ent_wd    = {lane_q, val_q};
		case (st_q)
			ST_CLEAR: begin
				slot_we   = 1'b1;
				slot_addr = clr_q;
			end
			ST_SLOT_CHK: begin
				ent_addr = se;
				if (do_insert) begin
					slot_we  = 1'b1;
					slot_wd  = {1'b1, count_q[SLOT_W-1:0]};
					ent_we   = 1'b1;
					ent_addr = count_q[SLOT_W-1:0];
				end
			end
			ST_LOGADD: begin
				ent_we = 1'b1;
				ent_wd = {lane_q, r_add};
			end
			default: ;
		endcase
	end

	assign req.ready       = (st_q == ST_IDLE);
	assign rsp.valid       = ov_q;
	assign rsp.found       = o_found_q;
	assign rsp.value_out   = o_val_q;
	assign rsp.entry_index = o_idx_q;
	assign rsp.status      = o_status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_CLEAR;
			clr_q      <= '0;
			clr_resp_q <= 1'b0;
			count_q    <= '0;
			max_fill_q <= MAXFILL_RST;
			ov_q       <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cfg_we) begin
				max_fill_q <= cfg_wdata;
			end
			if (st_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (accept && (action_t'(req.action) == ACT_CLEAR)) begin
				clr_q      <= '0;
				clr_resp_q <= 1'b1;
				count_q    <= '0;
			end
			if (do_insert) begin
				count_q <= count_q + 1'b1;
			end
			if ((st_q == ST_RESP) && out_free) begin
				ov_q <= 1'b1;
			end else if (rsp.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q  <= action_t'(req.action);
			lane_q <= {req.key_y, req.key_x};
			val_q  <= req.value_in;
			res_found_q  <= 1'b0;
			res_val_q    <= '0;
			res_idx_q    <= '0;
			res_status_q <= 1'b0;
		end
		if (hres.done) begin
			slot_q <= hres.slot;
			n_q    <= '0;
		end
		if (advance) begin
			slot_q <= slot_q + 1'b1;
			n_q    <= n_q + 1'b1;
		end
		if (exhausted) begin
			// every slot taken: lookup misses, an insert or accumulate is refused
			if (act_q == ACT_LOOKUP) begin
				res_val_q <= VAL_MISS;
			end else begin
				res_status_q <= 1'b1;
			end
		end
		if ((st_q == ST_SLOT_CHK) && !sv) begin
			if (act_q == ACT_LOOKUP) begin
				res_val_q <= VAL_MISS;
			end else if (full_c) begin
				res_status_q <= 1'b1;
			end else begin
				res_val_q <= val_q;
				res_idx_q <= IDX_W'(count_q[SLOT_W-1:0]);
			end
		end
		if ((st_q == ST_SLOT_CHK) && sv) begin
			ent_q <= se;
		end
		if ((st_q == ST_KEY_CMP) && key_hit) begin
			res_found_q <= 1'b1;
			res_val_q   <= ent_rd[VAL_W-1:0];
			res_idx_q   <= IDX_W'(ent_q);
			big_q       <= vbig;
			spok_q      <= (diff[VAL_W:SP_SHIFT+SP_W] == '0);
			spi_q       <= diff[SP_SHIFT+SP_W-1:SP_SHIFT];
		end
		if (st_q == ST_LOGADD) begin
			res_val_q <= r_add;
		end
		if ((st_q == ST_RESP) && out_free) begin
			o_found_q  <= res_found_q;
			o_val_q    <= res_val_q;
			o_idx_q    <= res_idx_q;
			o_status_q <= res_status_q;
		end
	end

endmodule

[src/pkh_checker.sv]
// ----------------------------------------------------------------------------
// pkh_checker
// Port-level checks on the pair-key hash map, bound to the top level.
// ----------------------------------------------------------------------------
module pkh_checker import pkh_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             req_valid,
	input logic             req_ready,
	input logic             rsp_valid,
	input logic             rsp_ready,
	input logic             rsp_found,
	input logic [VAL_W-1:0] rsp_value_out,
	input logic [IDX_W-1:0] rsp_entry_index,
	input logic             rsp_status
);

	// one request in flight: no back-to-back accept
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while previous one in flight");

	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status |-> !rsp_found && rsp_value_out == '0 && rsp_entry_index == '0)
		else $error("refused insert carries payload");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value_out))
		else $error("stalled response dropped or changed");

	a_reset_quiet: assert property (@(posedge clk)
		$rose(arst_n) |-> !rsp_valid && !req_ready)
		else $error("activity right after reset");

endmodule

bind pair_key_hash_map_log_accumulate pkh_checker u_pkh_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_found       (rsp.found),
	.rsp_value_out   (rsp.value_out),
	.rsp_entry_index (rsp.entry_index),
	.rsp_status      (rsp.status)
);

[verif/tb_pair_key_hash_map_log_accumulate.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pair_key_hash_map_log_accumulate
// Drives map requests (lookup, insert, accumulate, clear) through the request
// channel with bursty gaps, stalls the response channel on its own pattern,
// and checks every response against a local map model with its own hash,
// linear probe and softplus log-add. Directed rows come first, then random
// traffic over a small key pool so hits, collisions and full map all occur.
// ----------------------------------------------------------------------------
module tb_pair_key_hash_map_log_accumulate;
	import pkh_pkg::*;

	typedef struct packed {
		logic        found;
		logic [31:0] value;
		logic [9:0]  index;
		logic        status;
	} answer_t;

	typedef struct {
		action_t     act;
		logic [31:0] kx;
		logic [31:0] ky;
		logic [31:0] val;
		logic        typed;
		answer_t     ans;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [MAXFILL_W-1:0] cfg_wdata = '0;

	pkh_req_if req ();
	pkh_rsp_if rsp ();

	pair_key_hash_map_log_accumulate dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.req(req.sink), .rsp(rsp.source)
	);

	always #1 clk = ~clk;

	// model state
	logic        slot_used [TABLE_SLOTS];
	logic [9:0]  slot_entry [TABLE_SLOTS];
	logic [63:0] entry_key [TABLE_SLOTS];
	logic [31:0] entry_val [TABLE_SLOTS];
	int unsigned entries;
	int unsigned fill_cap;
	logic [15:0] softplus [SP_ENTRIES];

	answer_t pending_q [$];
	int errors = 0;
	int sent = 0;
	logic [31:0] pool_x [16];
	logic [31:0] pool_y [16];

	function automatic logic [63:0] rotl(logic [63:0] v, int r);
		return (v << r) | (v >> (64 - r));
	endfunction

	function automatic logic [9:0] home_of(logic [63:0] lane);
		logic [63:0] h;
		logic [63:0] k;
		h = 64'd1337 + PR5 + 64'd8;
		k = rotl(lane * PR2, 31) * PR1;
		h = h ^ k;
		h = rotl(h, 27) * PR1 + PR4;
		h = h ^ (h >> 33);
		h = h * PR2;
		h = h ^ (h >> 29);
		h = h * PR3;
		h = h ^ (h >> 32);
		return h[9:0];
	endfunction

	function automatic logic [15:0] ln1p_q16_m(logic [63:0] t);
		logic [63:0] z;
		logic [63:0] z2;
		logic [63:0] term;
		logic [63:0] acc;
		logic [63:0] k;
		z = (t << 30) / ((64'd2 << 30) + t);
		z2 = (z * z) >> 30;
		term = z;
		acc = 0;
		k = 1;
		while (term != 0) begin
			acc += term / k;
			term = (term * z2) >> 30;
			k += 2;
		end
		acc = (2 * acc + (64'd1 << 13)) >> 14;
		return acc[15:0];
	endfunction

	function automatic logic [31:0] log_sum(logic [31:0] a, logic [31:0] b);
		longint big;
		longint lit;
		longint r;
		longint d;
		big = $signed(a) > $signed(b) ? $signed(a) : $signed(b);
		lit = $signed(a) > $signed(b) ? $signed(b) : $signed(a);
		d = (big - lit) >>> 12;
		r = big + (d < SP_ENTRIES ? longint'(softplus[d]) : 0);
		if (r > 64'sd2147483647) r = 64'sd2147483647;
		return r[31:0];
	endfunction

	function automatic answer_t map_apply(action_t act, logic [31:0] kx,
			logic [31:0] ky, logic [31:0] val);
		answer_t a;
		logic [63:0] lane;
		int unsigned h;
		int unsigned n;
		logic hit;
		int unsigned lim;
		a = '0;
		lane = {ky, kx};
		hit = 1'b0;
		lim = fill_cap < TABLE_SLOTS ? fill_cap : TABLE_SLOTS;
		if (act == ACT_CLEAR) begin
			foreach (slot_used[i]) slot_used[i] = 1'b0;
			entries = 0;
			return a;
		end
		h = home_of(lane);
		for (n = 0; n < TABLE_SLOTS && slot_used[h]; n++) begin
			if (act != ACT_INSERT && entry_key[slot_entry[h]] == lane) begin
				hit = 1'b1;
				break;
			end
			h = (h + 1) % TABLE_SLOTS;
		end
		if (hit) begin
			a.found = 1'b1;
			a.index = slot_entry[h];
			if (act == ACT_ACCUM)
				entry_val[slot_entry[h]] = log_sum(entry_val[slot_entry[h]], val);
			a.value = entry_val[slot_entry[h]];
		end else if (act == ACT_LOOKUP) begin
			a.value = VAL_MISS;
		end else if (entries >= lim || slot_used[h]) begin
			a.status = 1'b1;
		end else begin
			slot_used[h] = 1'b1;
			slot_entry[h] = entries[9:0];
			entry_key[entries] = lane;
			entry_val[entries] = val;
			a.index = entries[9:0];
			a.value = val;
			entries++;
		end
		return a;
	endfunction

	task automatic send(action_t act, logic [31:0] kx, logic [31:0] ky,
			logic [31:0] val, logic typed, answer_t ans);
		answer_t want;
		// bursty sender: random gap ahead of some requests
		if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		@(negedge clk);
		req.valid <= 1'b1;
		req.action <= act;
		req.key_x <= kx;
		req.key_y <= ky;
		req.value_in <= val;
		do @(posedge clk); while (!req.ready);
		want = map_apply(act, kx, ky, val);
		if (typed && want !== ans) begin
			errors++;
			if (errors <= 10) $display("row answer mismatch: table %h model %h", ans, want);
		end
		pending_q.push_back(want);
		sent++;
		@(negedge clk);
		req.valid <= 1'b0;
	endtask

	task automatic drain();
		while (pending_q.size() != 0) @(negedge clk);
		repeat (1100) @(negedge clk);
	endtask

	task automatic set_fill(logic [MAXFILL_W-1:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		fill_cap = v;
	endtask

	// response checker and receiver stall pattern
	always @(posedge clk) begin
		answer_t got;
		answer_t want;
		if (rsp.valid && rsp.ready) begin
			got = {rsp.found, rsp.value_out, rsp.entry_index, rsp.status};
			if (pending_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected response %h", got);
			end else begin
				want = pending_q.pop_front();
				if (got !== want) begin
					errors++;
					if (errors <= 10) $display("response mismatch: expected %h got %h", want, got);
				end
			end
		end
	end

	int stall_phase = 0;
	always @(negedge clk) begin
		stall_phase <= stall_phase + 1;
		if (stall_phase % 400 < 100) rsp.ready <= 1'b1;
		else rsp.ready <= ($urandom_range(0, 2) != 0);
	end

	initial begin
		#20000000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		row_t rows [$];
		row_t r;
		answer_t z;
		int k;
		int p;
		action_t act;
		req.valid = 1'b0;
		req.action = ACT_LOOKUP;
		req.key_x = '0;
		req.key_y = '0;
		req.value_in = '0;
		rsp.ready = 1'b0;
		foreach (softplus[i]) softplus[i] = 0;
		begin
			logic [63:0] e;
			e = ONE_Q30;
			for (int i = 0; i < SP_ENTRIES; i++) begin
				softplus[i] = ln1p_q16_m(e);
				e = (e * EXP_STEP_Q30 + (64'd1 << 29)) >> 30;
			end
		end
		foreach (slot_used[i]) slot_used[i] = 1'b0;
		entries = 0;
		fill_cap = 512;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		z = '0;
		// lookup on an empty map misses with -1.0
		r = '{ACT_LOOKUP, 32'h8000_0000, 32'h7FFF_FFFF, 0, 1, '{0, VAL_MISS, 0, 0}};
		rows.push_back(r);
		r = '{ACT_INSERT, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1,
			'{0, 32'h8000_0000, 0, 0}};
		rows.push_back(r);
		r = '{ACT_INSERT, 32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF, 1, '{0, 32'h7FFF_FFFF, 1, 0}};
		rows.push_back(r);
		r = '{ACT_LOOKUP, 32'h8000_0000, 32'h7FFF_FFFF, 0, 1, '{1, 32'h8000_0000, 0, 0}};
		rows.push_back(r);
		// saturating log-add at the top
		r = '{ACT_ACCUM, 32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF, 1, '{1, 32'h7FFF_FFFF, 1, 0}};
		rows.push_back(r);
		// equal values, far values, new key via accumulate
		r = '{ACT_ACCUM, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, z};
		rows.push_back(r);
		r = '{ACT_ACCUM, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 0, z};
		rows.push_back(r);
		r = '{ACT_ACCUM, 32'h1, 32'h2, 32'hFFFF_0000, 0, z};
		rows.push_back(r);
		r = '{ACT_ACCUM, 32'h1, 32'h2, 32'hFFFF_8000, 0, z};
		rows.push_back(r);
		// duplicate insert becomes a new entry
		r = '{ACT_INSERT, 32'h1, 32'h2, 32'h5, 0, z};
		rows.push_back(r);
		r = '{ACT_LOOKUP, 32'h1, 32'h2, 0, 0, z};
		rows.push_back(r);
		r = '{ACT_CLEAR, 32'h1, 32'h2, 0, 1, '{0, 0, 0, 0}};
		rows.push_back(r);
		r = '{ACT_LOOKUP, 32'h1, 32'h2, 0, 1, '{0, VAL_MISS, 0, 0}};
		rows.push_back(r);
		foreach (rows[i]) send(rows[i].act, rows[i].kx, rows[i].ky, rows[i].val,
			rows[i].typed, rows[i].ans);

		// fill of 1 refuses a second key, added via accumulate; fill of 0 any insert
		set_fill(11'd1);
		send(ACT_INSERT, 32'hA, 32'hB, 32'h10, 1, '{0, 32'h10, 0, 0});
		send(ACT_ACCUM, 32'hC, 32'hD, 32'h10, 1, '{0, 0, 0, 1});
		send(ACT_CLEAR, 0, 0, 0, 1, '{0, 0, 0, 0});
		set_fill(11'd0);
		send(ACT_INSERT, 32'hA, 32'hB, 32'h10, 1, '{0, 0, 0, 1});

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: set_fill(11'd2047);
				1: set_fill(11'd24);
				2: set_fill(11'd1024);
				default: set_fill(11'd512);
			endcase
			foreach (pool_x[i]) begin
				pool_x[i] = $urandom;
				pool_y[i] = $urandom;
			end
			for (k = 0; k < 235; k++) begin
				p = $urandom_range(0, 15);
				case ($urandom_range(0, 19))
					0: act = ACT_CLEAR;
					1, 2, 3, 4, 5: act = ACT_LOOKUP;
					6, 7, 8: act = ACT_INSERT;
					default: act = ACT_ACCUM;
				endcase
				if ($urandom_range(0, 4) == 0)
					send(act, $urandom, $urandom, $urandom, 0, z);
				else
					send(act, pool_x[p], pool_y[p],
						$urandom_range(0, 1) ? $urandom : ($urandom_range(0, 1 << 20) - (1 << 19)),
						0, z);
				// hold off until all responses are back
				if (k == 100)
					while (pending_q.size() != 0) @(negedge clk);
			end
		end

		k = 0;
		while (pending_q.size() != 0 && k < 200000) begin
			@(negedge clk);
			k++;
		end
		repeat (200) @(negedge clk);
		if (errors == 0 && pending_q.size() == 0) $display("TEST PASSED");
		else $display("TEST FAILED");
		$finish;
	end

endmodule

[pair_key_hash_map_log_accumulate.f]
src/pkh_pkg.sv
src/pkh_if.sv
src/pkh_ram.sv
src/pkh_hash.sv
src/pair_key_hash_map_log_accumulate.sv
src/pkh_checker.sv
verif/tb_pair_key_hash_map_log_accumulate.sv
